@@ rtl/pdrc_pkg.sv @@
// Shared types, constants and register map of the pileup difference run classifier.
package pdrc_pkg;

  localparam int DEF_COUNT_WIDTH    = 16;
  localparam int DEF_POSITION_WIDTH = 32;

  localparam int RUN_W      = 32;
  localparam int KIND_W     = 3;
  localparam int WINDOW_W   = 56;
  localparam int COVMIN_W   = 16;
  localparam int FRACTION_W = 17;
  localparam int FRAC_BITS  = 16;
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 4;
  localparam int NUM_BASES  = 5;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [RUN_W-1:0] LEN_MAX = '1;

  // Window byte of the reference base; also the homopolymer reach on each side.
  localparam int REF_BYTE = 3;
  localparam int HP_REACH = 3;

  localparam logic [7:0] BASE_LETTER [NUM_BASES] = '{8'h41, 8'h43, 8'h47, 8'h54, 8'h4E};

  localparam logic [1:0] REG_COVERAGE_FLOOR   = 2'd0;
  localparam logic [1:0] REG_MIN_FRACTION     = 2'd1;
  localparam logic [1:0] REG_SKIP_HOMOPOLYMER = 2'd2;
  localparam logic [1:0] REG_REFERENCE_LENGTH = 2'd3;

  typedef enum logic [KIND_W-1:0] {
    KIND_UNCOVERED   = 3'd0,
    KIND_INSERTION   = 3'd1,
    KIND_DELETION    = 3'd2,
    KIND_MISMATCH    = 3'd3,
    KIND_HOMOPOLYMER = 3'd4,
    KIND_NONE        = 3'd5,
    KIND_CLEAR       = 3'd6
  } kind_t;

  typedef struct packed {
    logic [COVMIN_W-1:0]   coverage_floor;
    logic [FRACTION_W-1:0] min_fraction;
    logic                  skip_homopolymer;
    logic [RUN_W-1:0]      reference_length;
  } cfg_t;

  typedef struct packed {
    logic  is_end;
    logic  gap_valid;
    logic  gap_sat;
    logic  col_valid;
    kind_t col_kind;
  } item_ctl_t;

endpackage

@@ rtl/pileup_diff_run_classifier_top.sv @@
// Top level of the pileup difference run classifier with its configuration registers.
// Takes one request per clock cycle while in_stall is low. A column request passes
// two front-end pipeline registers (coverage sum, then the fraction-times-coverage
// multiply) and is classified into a four-entry queue; the run builder behind it handles
// a request directly, but one with a gap in positions before a column that adds to a run
// first as a gap step and then as a column step. The result register delivers one result
// per cycle while out_stall is low, so a column that closes two runs delivers them in turn.
// Registers: coverage floor at 0x0, min_fraction at 0x4, skip_homopolymer at 0x8,
// reference_length at 0xC; write them only while the block is idle.
module pileup_diff_run_classifier_top #(
  parameter int COUNT_WIDTH    = pdrc_pkg::DEF_COUNT_WIDTH,
  parameter int POSITION_WIDTH = pdrc_pkg::DEF_POSITION_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pdrc_pkg::ADDR_W-1:0]   paddr,
  input  logic [pdrc_pkg::DATA_W-1:0]   pwdata,
  output logic [pdrc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_mode,
  input  logic [POSITION_WIDTH-1:0]     in_position,
  input  logic [COUNT_WIDTH-1:0]        in_count_a,
  input  logic [COUNT_WIDTH-1:0]        in_count_c,
  input  logic [COUNT_WIDTH-1:0]        in_count_g,
  input  logic [COUNT_WIDTH-1:0]        in_count_t,
  input  logic [COUNT_WIDTH-1:0]        in_count_n,
  input  logic [COUNT_WIDTH-1:0]        in_deleted_reads,
  input  logic [COUNT_WIDTH-1:0]        in_inserted_reads,
  input  logic [pdrc_pkg::WINDOW_W-1:0] in_ref_window,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pdrc_pkg::RUN_W-1:0]    out_run_start,
  output logic [pdrc_pkg::KIND_W-1:0]   out_run_kind,
  output logic [pdrc_pkg::RUN_W-1:0]    out_run_length,
  output logic                          out_last_result
);
  import pdrc_pkg::*;

  localparam int CTL_W = $bits(item_ctl_t);
  localparam int QW    = CTL_W + POSITION_WIDTH + RUN_W + POSITION_WIDTH;

  cfg_t                      cfg_r;
  logic                      cfg_wr;
  logic [1:0]                reg_idx;

  logic                      q_wr, q_full, q_rd, q_valid;
  item_ctl_t                 f_ctl, h_ctl;
  logic [POSITION_WIDTH-1:0] f_gap_start, f_pos, h_gap_start, h_pos;
  logic [RUN_W-1:0]          f_gap_len, h_gap_len;
  logic [QW-1:0]             q_wdata, q_rdata;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_COVERAGE_FLOOR:   cfg_r.coverage_floor   <= pwdata[COVMIN_W-1:0];
        REG_MIN_FRACTION:     cfg_r.min_fraction     <= pwdata[FRACTION_W-1:0];
        REG_SKIP_HOMOPOLYMER: cfg_r.skip_homopolymer <= pwdata[0];
        REG_REFERENCE_LENGTH: cfg_r.reference_length <= pwdata[RUN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_COVERAGE_FLOOR:   prdata = DATA_W'(cfg_r.coverage_floor);
      REG_MIN_FRACTION:     prdata = DATA_W'(cfg_r.min_fraction);
      REG_SKIP_HOMOPOLYMER: prdata = DATA_W'(cfg_r.skip_homopolymer);
      REG_REFERENCE_LENGTH: prdata = DATA_W'(cfg_r.reference_length);
      default:              prdata = '0;
    endcase
  end

  pdrc_front #(
    .COUNT_WIDTH   (COUNT_WIDTH),
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_position      (in_position),
    .in_count_a       (in_count_a),
    .in_count_c       (in_count_c),
    .in_count_g       (in_count_g),
    .in_count_t       (in_count_t),
    .in_count_n       (in_count_n),
    .in_deleted_reads (in_deleted_reads),
    .in_inserted_reads(in_inserted_reads),
    .in_ref_window    (in_ref_window),
    .q_wr             (q_wr),
    .q_full           (q_full),
    .q_ctl            (f_ctl),
    .q_gap_start      (f_gap_start),
    .q_gap_len        (f_gap_len),
    .q_pos            (f_pos)
  );

  assign q_wdata = {f_ctl, f_gap_start, f_gap_len, f_pos};

  pdrc_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_valid(q_valid),
    .rd_data (q_rdata)
  );

  assign h_ctl       = item_ctl_t'(q_rdata[QW-1 -: CTL_W]);
  assign h_gap_start = q_rdata[POSITION_WIDTH+RUN_W+POSITION_WIDTH-1 -: POSITION_WIDTH];
  assign h_gap_len   = q_rdata[POSITION_WIDTH+RUN_W-1 -: RUN_W];
  assign h_pos       = q_rdata[POSITION_WIDTH-1:0];

  pdrc_back #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .hd_valid       (q_valid),
    .hd_ctl         (h_ctl),
    .hd_gap_start   (h_gap_start),
    .hd_gap_len     (h_gap_len),
    .hd_pos         (h_pos),
    .hd_pop         (q_rd),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_run_start  (out_run_start),
    .out_run_kind   (out_run_kind),
    .out_run_length (out_run_length),
    .out_last_result(out_last_result)
  );

endmodule

@@ rtl/pdrc_front.sv @@
// Front end: gap detection, coverage, proportion tests and column classification.
module pdrc_front #(
  parameter int COUNT_WIDTH    = pdrc_pkg::DEF_COUNT_WIDTH,
  parameter int POSITION_WIDTH = pdrc_pkg::DEF_POSITION_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pdrc_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_mode,
  input  logic [POSITION_WIDTH-1:0]     in_position,
  input  logic [COUNT_WIDTH-1:0]        in_count_a,
  input  logic [COUNT_WIDTH-1:0]        in_count_c,
  input  logic [COUNT_WIDTH-1:0]        in_count_g,
  input  logic [COUNT_WIDTH-1:0]        in_count_t,
  input  logic [COUNT_WIDTH-1:0]        in_count_n,
  input  logic [COUNT_WIDTH-1:0]        in_deleted_reads,
  input  logic [COUNT_WIDTH-1:0]        in_inserted_reads,
  input  logic [pdrc_pkg::WINDOW_W-1:0] in_ref_window,
  output logic                          q_wr,
  input  logic                          q_full,
  output pdrc_pkg::item_ctl_t           q_ctl,
  output logic [POSITION_WIDTH-1:0]     q_gap_start,
  output logic [pdrc_pkg::RUN_W-1:0]    q_gap_len,
  output logic [POSITION_WIDTH-1:0]     q_pos
);
  import pdrc_pkg::*;

  localparam int CVW = COUNT_WIDTH + 3;
  localparam int PRW = CVW + FRACTION_W;
  localparam int DW  = (POSITION_WIDTH > RUN_W) ? POSITION_WIDTH : RUN_W;
  localparam int HW  = DW + 1;
  localparam int MCW = (CVW > COVMIN_W) ? CVW : COVMIN_W;

  function automatic logic passes(input logic [COUNT_WIDTH-1:0] cnt,
                                  input logic [PRW-1:0] prod);
    passes = PRW'({cnt, {FRAC_BITS{1'b0}}}) >= prod;
  endfunction

  logic                      adv1, adv2, acc;
  logic                      v1_r, v2_r;
  logic [POSITION_WIDTH:0]   ne_r;
  logic [POSITION_WIDTH:0]   pos_ext;
  logic [POSITION_WIDTH-1:0] diff;
  logic [DW-1:0]             diff_ext;
  logic                      gap, gap_sat;
  logic [CVW-1:0]            cov;

  logic                      r1_mode, r1_gap, r1_gap_sat;
  logic [POSITION_WIDTH-1:0] r1_pos, r1_gap_start;
  logic [RUN_W-1:0]          r1_gap_len;
  logic [COUNT_WIDTH-1:0]    r1_cnt [NUM_BASES];
  logic [COUNT_WIDTH-1:0]    r1_del, r1_ins;
  logic [WINDOW_W-1:0]       r1_win;
  logic [CVW-1:0]            r1_cov;

  logic                      r2_mode, r2_gap, r2_gap_sat;
  logic [POSITION_WIDTH-1:0] r2_pos, r2_gap_start;
  logic [RUN_W-1:0]          r2_gap_len;
  logic [COUNT_WIDTH-1:0]    r2_cnt [NUM_BASES];
  logic [COUNT_WIDTH-1:0]    r2_del, r2_ins;
  logic [WINDOW_W-1:0]       r2_win;
  logic [PRW-1:0]            r2_prod;
  logic                      r2_low, r2_fwd, r2_bwd;

  logic                      hp, mism;
  logic [7:0]                ref_base;

  assign q_wr     = v2_r && !q_full;
  assign adv2     = !v2_r || !q_full;
  assign adv1     = !v1_r || adv2;
  assign in_stall = !adv1;
  assign acc      = in_valid && adv1;

  assign pos_ext  = {1'b0, in_position};
  assign gap      = !in_mode && (pos_ext > ne_r);
  assign diff     = in_position - ne_r[POSITION_WIDTH-1:0];
  assign diff_ext = DW'(diff);
  assign gap_sat  = diff_ext > DW'(LEN_MAX);
  assign cov      = CVW'(in_count_a) + CVW'(in_count_c) + CVW'(in_count_g)
                  + CVW'(in_count_t) + CVW'(in_count_n) + CVW'(in_deleted_reads);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      ne_r <= '0;
    end else begin
      if (adv2) begin
        v2_r <= v1_r;
      end
      if (adv1) begin
        v1_r <= in_valid;
      end
      if (acc) begin
        ne_r <= in_mode ? '0 : pos_ext + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      r1_mode      <= in_mode;
      r1_gap       <= gap;
      r1_gap_sat   <= gap_sat;
      r1_pos       <= in_position;
      r1_gap_start <= ne_r[POSITION_WIDTH-1:0];
      r1_gap_len   <= gap_sat ? LEN_MAX : diff_ext[RUN_W-1:0];
      r1_cnt[0]    <= in_count_a;
      r1_cnt[1]    <= in_count_c;
      r1_cnt[2]    <= in_count_g;
      r1_cnt[3]    <= in_count_t;
      r1_cnt[4]    <= in_count_n;
      r1_del       <= in_deleted_reads;
      r1_ins       <= in_inserted_reads;
      r1_win       <= in_ref_window;
      r1_cov       <= cov;
    end
    if (adv2 && v1_r) begin
      r2_mode      <= r1_mode;
      r2_gap       <= r1_gap;
      r2_gap_sat   <= r1_gap_sat;
      r2_pos       <= r1_pos;
      r2_gap_start <= r1_gap_start;
      r2_gap_len   <= r1_gap_len;
      r2_cnt       <= r1_cnt;
      r2_del       <= r1_del;
      r2_ins       <= r1_ins;
      r2_win       <= r1_win;
      r2_prod      <= PRW'(cfg.min_fraction) * PRW'(r1_cov);
      r2_low       <= (r1_cov == '0) || (MCW'(r1_cov) < MCW'(cfg.coverage_floor));
      r2_fwd       <= (HW'(r1_pos) + HW'(HP_REACH)) < HW'(cfg.reference_length);
      r2_bwd       <= r1_pos >= POSITION_WIDTH'(HP_REACH);
    end
  end

  assign ref_base = r2_win[8*REF_BYTE +: 8];

  always_comb begin
    hp = (r2_fwd && r2_win[39:32] == r2_win[47:40] && r2_win[39:32] == r2_win[55:48])
      || (r2_bwd && r2_win[23:16] == r2_win[15:8] && r2_win[23:16] == r2_win[7:0]);
    mism = 1'b0;
    for (int k = 0; k < NUM_BASES; k++) begin
      if (BASE_LETTER[k] != ref_base && passes(r2_cnt[k], r2_prod)) begin
        mism = 1'b1;
      end
    end
    q_ctl           = '0;
    q_ctl.is_end    = r2_mode;
    q_ctl.gap_valid = r2_gap;
    q_ctl.gap_sat   = r2_gap_sat;
    q_ctl.col_kind  = KIND_UNCOVERED;
    if (!r2_mode) begin
      if (r2_low) begin
        q_ctl.col_valid = 1'b1;
        q_ctl.col_kind  = KIND_UNCOVERED;
      end else if (passes(r2_del, r2_prod)) begin
        q_ctl.col_valid = hp ? !cfg.skip_homopolymer : 1'b1;
        q_ctl.col_kind  = hp ? KIND_HOMOPOLYMER : KIND_INSERTION;
      end else if (mism) begin
        q_ctl.col_valid = 1'b1;
        q_ctl.col_kind  = KIND_MISMATCH;
      end else if (passes(r2_ins, r2_prod)) begin
        q_ctl.col_valid = hp ? !cfg.skip_homopolymer : 1'b1;
        q_ctl.col_kind  = hp ? KIND_HOMOPOLYMER : KIND_DELETION;
      end
    end
  end

  assign q_gap_start = r2_gap_start;
  assign q_gap_len   = r2_gap_len;
  assign q_pos       = r2_pos;

endmodule

@@ rtl/pdrc_queue.sv @@
// Small register queue between the classifying front end and the run builder.
module pdrc_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic             rd_valid,
  output logic [WIDTH-1:0] rd_data
);
  import pdrc_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_wr, do_rd;

  assign full     = count_r == CNT_W'(QUEUE_DEPTH);
  assign rd_valid = count_r != '0;
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

@@ rtl/pdrc_back.sv @@
// Run builder: merges classified columns and gaps into runs and drives the result register.
module pdrc_back #(
  parameter int POSITION_WIDTH = pdrc_pkg::DEF_POSITION_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        hd_valid,
  input  pdrc_pkg::item_ctl_t         hd_ctl,
  input  logic [POSITION_WIDTH-1:0]   hd_gap_start,
  input  logic [pdrc_pkg::RUN_W-1:0]  hd_gap_len,
  input  logic [POSITION_WIDTH-1:0]   hd_pos,
  output logic                        hd_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pdrc_pkg::RUN_W-1:0]  out_run_start,
  output logic [pdrc_pkg::KIND_W-1:0] out_run_kind,
  output logic [pdrc_pkg::RUN_W-1:0]  out_run_length,
  output logic                        out_last_result
);
  import pdrc_pkg::*;

  localparam int DW = (POSITION_WIDTH > RUN_W) ? POSITION_WIDTH : RUN_W;
  localparam int AW = DW + 1;

  logic                      open_valid_r, col_seen_r, phase_r;
  logic [POSITION_WIDTH-1:0] open_start_r;
  kind_t                     open_kind_r;
  logic [RUN_W-1:0]          open_length_r;

  logic                      out_valid_r, out_last_r;
  logic [RUN_W-1:0]          out_start_r, out_length_r;
  kind_t                     out_kind_r;

  logic                      step_gap, st_active, merge, len_sat, emit, go, out_free;
  logic                      end_ok, col_emits, last;
  logic [POSITION_WIDTH-1:0] st_start;
  kind_t                     st_kind;
  logic [RUN_W-1:0]          st_len, merged_len;
  logic [RUN_W:0]            len_sum;
  logic [AW-1:0]             end_sum;
  logic [RUN_W-1:0]          em_start, em_length;
  kind_t                     em_kind;

  assign step_gap  = hd_ctl.gap_valid && !phase_r && !hd_ctl.is_end;
  assign st_start  = step_gap ? hd_gap_start : hd_pos;
  assign st_kind   = step_gap ? KIND_UNCOVERED : hd_ctl.col_kind;
  assign st_len    = step_gap ? hd_gap_len : RUN_W'(1);
  assign st_active = step_gap || hd_ctl.col_valid;

  assign end_sum    = AW'(open_start_r) + AW'(open_length_r);
  assign merge      = open_valid_r && open_kind_r == st_kind && end_sum == AW'(st_start);
  assign len_sum    = {1'b0, open_length_r} + {1'b0, st_len};
  assign len_sat    = len_sum[RUN_W];
  assign merged_len = len_sat ? LEN_MAX : len_sum[RUN_W-1:0];

  assign emit     = hd_valid && (hd_ctl.is_end || (st_active && open_valid_r && !merge));
  assign out_free = !out_valid_r || !out_stall;
  assign go       = hd_valid && (!emit || out_free);
  assign hd_pop   = go && !(step_gap && hd_ctl.col_valid);

  // After a gap step the open run is uncovered and ends at the column unless its length saturated.
  assign end_ok    = merge ? !len_sat : !hd_ctl.gap_sat;
  assign col_emits = hd_ctl.col_valid && !(hd_ctl.col_kind == KIND_UNCOVERED && end_ok);
  assign last      = hd_ctl.is_end || !step_gap || !col_emits;

  always_comb begin
    em_start  = RUN_W'(open_start_r);
    em_kind   = open_kind_r;
    em_length = open_length_r;
    if (hd_ctl.is_end && !open_valid_r) begin
      em_start  = '0;
      em_kind   = col_seen_r ? KIND_CLEAR : KIND_NONE;
      em_length = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_valid_r  <= 1'b0;
      open_start_r  <= '0;
      open_kind_r   <= KIND_UNCOVERED;
      open_length_r <= '0;
      col_seen_r    <= 1'b0;
      phase_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (go) begin
        if (hd_ctl.is_end) begin
          open_valid_r  <= 1'b0;
          open_start_r  <= '0;
          open_kind_r   <= KIND_UNCOVERED;
          open_length_r <= '0;
          col_seen_r    <= 1'b0;
        end else begin
          col_seen_r <= 1'b1;
          if (st_active) begin
            if (merge) begin
              open_length_r <= merged_len;
            end else begin
              open_valid_r  <= 1'b1;
              open_start_r  <= st_start;
              open_kind_r   <= st_kind;
              open_length_r <= st_len;
            end
          end
        end
        phase_r <= step_gap && hd_ctl.col_valid;
      end
      if (go && emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && emit) begin
      out_start_r  <= em_start;
      out_kind_r   <= em_kind;
      out_length_r <= em_length;
      out_last_r   <= last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_run_start   = out_start_r;
  assign out_run_kind    = out_kind_r;
  assign out_run_length  = out_length_r;
  assign out_last_result = out_last_r;

endmodule

@@ tb/tb_pileup_diff_run_classifier_top.sv @@
// Self-checking testbench for the pileup difference run classifier top level.
`timescale 1ns / 100ps

module tb_pileup_diff_run_classifier_top;
  import pdrc_pkg::*;

  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 6;
  localparam int SETTLE_CYCLES = 20;
  localparam int LONG_HOLD     = 300;
  localparam int RANDOM_ITEMS  = 100;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int TIMEOUT_NS    = 5_000_000;

  localparam logic [55:0] WIN_RIGHT_HP  = 56'h41414143475447;
  localparam logic [55:0] WIN_LEFT_HP   = 56'h41474343545454;
  localparam logic [55:0] WIN_PLAIN     = 56'h47415443544147;
  localparam logic [55:0] WIN_LOWER_REF = 56'h47415461544147;

  typedef struct packed {
    logic        mode;
    logic [31:0] position;
    logic [15:0] count_a;
    logic [15:0] count_c;
    logic [15:0] count_g;
    logic [15:0] count_t;
    logic [15:0] count_n;
    logic [15:0] deleted_reads;
    logic [15:0] inserted_reads;
    logic [55:0] ref_window;
  } column_req_t;

  typedef struct packed {
    logic [31:0] start;
    kind_t       kind;
    logic [31:0] length;
    logic        last;
  } run_t;

  typedef enum {
    COL_CLEAN, COL_DELETION, COL_MISMATCH, COL_INSERTION, COL_LOWCOV, COL_EMPTY, COL_WILD
  } col_flavor_t;

  class pileup_run_tracker;
    logic [15:0] cov_floor;
    logic [16:0] frac_floor;
    logic        skip_hp;
    logic [31:0] ref_span;
    logic        open_valid;
    logic [31:0] open_start;
    kind_t       open_kind;
    logic [31:0] open_length;
    logic [32:0] next_pos;
    logic        column_seen;
    run_t        pending_runs[$];
    run_t        new_runs[$];
    int          failures;

    function new();
      cov_floor  = '0;
      frac_floor = '0;
      skip_hp    = 1'b0;
      ref_span   = '0;
      failures   = 0;
      clear_contig();
    endfunction

    function void write_register(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_COVERAGE_FLOOR:   cov_floor  = value[15:0];
        REG_MIN_FRACTION:     frac_floor = value[16:0];
        REG_SKIP_HOMOPOLYMER: skip_hp    = value[0];
        REG_REFERENCE_LENGTH: ref_span   = value;
        default: ;
      endcase
    endfunction

    function void clear_contig();
      open_valid  = 1'b0;
      open_start  = '0;
      open_kind   = KIND_UNCOVERED;
      open_length = '0;
      next_pos    = '0;
      column_seen = 1'b0;
    endfunction

    function void emit_run(logic [31:0] s, kind_t k, logic [31:0] l);
      run_t r;
      r.start  = s;
      r.kind   = k;
      r.length = l;
      r.last   = 1'b0;
      new_runs = {new_runs, r};
    endfunction

    function void add_run(logic [31:0] s, kind_t k, logic [31:0] l);
      logic [32:0] sum;
      if (open_valid && open_kind == k &&
          ({1'b0, open_start} + {1'b0, open_length}) == {1'b0, s}) begin
        sum = {1'b0, open_length} + {1'b0, l};
        open_length = sum[32] ? LEN_MAX : sum[31:0];
        return;
      end
      if (open_valid) emit_run(open_start, open_kind, open_length);
      open_valid  = 1'b1;
      open_start  = s;
      open_kind   = k;
      open_length = l;
    endfunction

    function bit share_passes(logic [15:0] n, logic [18:0] cov);
      logic [39:0] lhs;
      logic [39:0] rhs;
      lhs = {8'd0, n, 16'd0};
      rhs = 40'(frac_floor) * 40'(cov);
      return lhs >= rhs;
    endfunction

    function bit homopolymer_at(logic [31:0] pos, logic [55:0] w);
      logic [32:0] reach;
      reach = {1'b0, pos} + 33'(HP_REACH);
      if (reach < {1'b0, ref_span} && w[39:32] == w[47:40] && w[39:32] == w[55:48])
        return 1'b1;
      if (pos >= HP_REACH && w[23:16] == w[15:8] && w[23:16] == w[7:0])
        return 1'b1;
      return 1'b0;
    endfunction

    function void indel_column(logic [31:0] pos, logic [55:0] w, kind_t k);
      if (homopolymer_at(pos, w)) begin
        if (!skip_hp) add_run(pos, KIND_HOMOPOLYMER, 32'd1);
      end else begin
        add_run(pos, k, 32'd1);
      end
    endfunction

    function void classify_request(column_req_t q);
      logic [15:0] bases [NUM_BASES];
      logic [18:0] cov;
      logic        differs;
      new_runs.delete();
      if (q.mode) begin
        if (open_valid) emit_run(open_start, open_kind, open_length);
        else if (!column_seen) emit_run('0, KIND_NONE, '0);
        else emit_run('0, KIND_CLEAR, '0);
        clear_contig();
      end else begin
        bases = '{q.count_a, q.count_c, q.count_g, q.count_t, q.count_n};
        column_seen = 1'b1;
        if ({1'b0, q.position} > next_pos)
          add_run(next_pos[31:0], KIND_UNCOVERED, q.position - next_pos[31:0]);
        next_pos = {1'b0, q.position} + 33'd1;
        cov = q.count_a + q.count_c + q.count_g + q.count_t + q.count_n + q.deleted_reads;
        differs = 1'b0;
        if (cov == 0 || cov < cov_floor) begin
          add_run(q.position, KIND_UNCOVERED, 32'd1);
        end else if (share_passes(q.deleted_reads, cov)) begin
          indel_column(q.position, q.ref_window, KIND_INSERTION);
        end else begin
          for (int i = 0; i < NUM_BASES; i++) begin
            if (!differs && BASE_LETTER[i] != q.ref_window[8*REF_BYTE +: 8] &&
                share_passes(bases[i], cov))
              differs = 1'b1;
          end
          if (differs) add_run(q.position, KIND_MISMATCH, 32'd1);
          else if (share_passes(q.inserted_reads, cov))
            indel_column(q.position, q.ref_window, KIND_DELETION);
        end
      end
      if (new_runs.size() > 0) new_runs[new_runs.size() - 1].last = 1'b1;
      pending_runs = {pending_runs, new_runs};
    endfunction

    function void check_run(run_t got);
      run_t want;
      if (pending_runs.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected run: start %h kind %0d length %h last %b",
                   got.start, got.kind, got.length, got.last);
        return;
      end
      want = pending_runs.pop_front();
      if (got.start !== want.start || got.kind !== want.kind ||
          got.length !== want.length || got.last !== want.last) begin
        failures++;
        if (failures <= 10)
          $display("run mismatch: expected start %h kind %0d length %h last %b, %s",
                   want.start, want.kind, want.length, want.last,
                   $sformatf("got start %h kind %0d length %h last %b",
                             got.start, got.kind, got.length, got.last));
      end
    endfunction

    function int outstanding();
      return pending_runs.size();
    endfunction

    function void count_leftover();
      if (pending_runs.size() > 0) begin
        failures += pending_runs.size();
        $display("%0d expected runs never arrived", pending_runs.size());
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid;
  logic              in_stall;
  column_req_t       req;
  logic              out_valid;
  logic              out_stall;
  logic [RUN_W-1:0]  out_run_start;
  logic [KIND_W-1:0] out_run_kind;
  logic [RUN_W-1:0]  out_run_length;
  logic              out_last_result;

  bit in_calm;
  bit out_calm;
  bit hold_req;
  int random_items;

  pileup_run_tracker board = new();

  pileup_diff_run_classifier_top i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (req.mode),
    .in_position       (req.position),
    .in_count_a        (req.count_a),
    .in_count_c        (req.count_c),
    .in_count_g        (req.count_g),
    .in_count_t        (req.count_t),
    .in_count_n        (req.count_n),
    .in_deleted_reads  (req.deleted_reads),
    .in_inserted_reads (req.inserted_reads),
    .in_ref_window     (req.ref_window),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_run_start     (out_run_start),
    .out_run_kind      (out_run_kind),
    .out_run_length    (out_run_length),
    .out_last_result   (out_last_result)
  );

  initial clk = 1'b0;
  always #(HALF_PERIOD) clk = ~clk;

  always @(posedge clk) begin : monitor
    run_t seen;
    if (rst_n) begin
      if (in_valid && !in_stall) board.classify_request(req);
      if (out_valid && !out_stall) begin
        seen.start  = out_run_start;
        seen.kind   = kind_t'(out_run_kind);
        seen.length = out_run_length;
        seen.last   = out_last_result;
        board.check_run(seen);
      end
    end
  end

  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic column_req_t column_of(logic [31:0] pos, logic [15:0] a, logic [15:0] c,
                                            logic [15:0] g, logic [15:0] t, logic [15:0] n,
                                            logic [15:0] del, logic [15:0] ins,
                                            logic [55:0] win);
    column_req_t q;
    q.mode           = 1'b0;
    q.position       = pos;
    q.count_a        = a;
    q.count_c        = c;
    q.count_g        = g;
    q.count_t        = t;
    q.count_n        = n;
    q.deleted_reads  = del;
    q.inserted_reads = ins;
    q.ref_window     = win;
    return q;
  endfunction

  function automatic column_req_t end_request();
    column_req_t q;
    q = column_of($urandom(), 16'($urandom()), 16'($urandom()), 16'($urandom()),
                  16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
                  56'({$urandom(), $urandom()}));
    q.mode = 1'b1;
    return q;
  endfunction

  function automatic col_flavor_t pick_flavor(col_flavor_t prev);
    int r;
    if ($urandom_range(0, 9) < 6) return prev;
    r = $urandom_range(0, 19);
    if (r < 5) return COL_CLEAN;
    if (r < 8) return COL_DELETION;
    if (r < 11) return COL_MISMATCH;
    if (r < 14) return COL_INSERTION;
    if (r < 16) return COL_LOWCOV;
    if (r < 17) return COL_EMPTY;
    return COL_WILD;
  endfunction

  function automatic column_req_t make_column(logic [31:0] pos, col_flavor_t flavor);
    logic [15:0] c [NUM_BASES];
    logic [7:0]  w [7];
    logic [15:0] del;
    logic [15:0] ins;
    logic [55:0] win;
    int          ri;
    int          oi;
    int          depth;
    int          shape;
    ri = $urandom_range(0, NUM_BASES - 1);
    oi = (ri + $urandom_range(1, NUM_BASES - 1)) % NUM_BASES;
    for (int k = 0; k < 7; k++) w[k] = BASE_LETTER[$urandom_range(0, NUM_BASES - 1)];
    w[REF_BYTE] = ($urandom_range(0, 9) == 0) ? 8'($urandom()) : BASE_LETTER[ri];
    shape = $urandom_range(0, 3);
    if (shape == 0 || shape == 2) begin
      w[5] = w[4];
      w[6] = w[4];
    end
    if (shape == 1 || shape == 2) begin
      w[1] = w[2];
      w[0] = w[2];
    end
    win = {w[6], w[5], w[4], w[3], w[2], w[1], w[0]};
    depth = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 20000) : $urandom_range(4, 40);
    for (int k = 0; k < NUM_BASES; k++) c[k] = 16'($urandom_range(0, depth / 16));
    del = '0;
    ins = '0;
    case (flavor)
      COL_CLEAN: c[ri] = 16'(depth);
      COL_DELETION: begin
        c[ri] = 16'(depth / 3);
        del   = 16'(depth);
      end
      COL_MISMATCH: begin
        c[ri] = 16'(depth / 4);
        c[oi] = 16'(depth);
      end
      COL_INSERTION: begin
        c[ri] = 16'(depth);
        ins   = 16'(depth * 3 / 4);
      end
      COL_LOWCOV: begin
        for (int k = 0; k < NUM_BASES; k++) c[k] = '0;
        c[ri] = 16'($urandom_range(1, 3));
      end
      COL_EMPTY: begin
        for (int k = 0; k < NUM_BASES; k++) c[k] = '0;
        ins = 16'($urandom_range(0, 5));
      end
      default: begin
        for (int k = 0; k < NUM_BASES; k++) c[k] = 16'($urandom());
        del = 16'($urandom());
        ins = 16'($urandom());
        win = 56'({$urandom(), $urandom()});
      end
    endcase
    return column_of(pos, c[0], c[1], c[2], c[3], c[4], del, ins, win);
  endfunction

  task automatic send_request(column_req_t item);
    int gap;
    gap = pick_gap(in_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req      <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.outstanding() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.write_register(idx, value);
  endtask

  task automatic configure(logic [31:0] cov, logic [31:0] frac, logic [31:0] skip,
                           logic [31:0] len);
    wait_idle();
    write_reg(REG_COVERAGE_FLOOR, cov);
    write_reg(REG_MIN_FRACTION, frac);
    write_reg(REG_SKIP_HOMOPOLYMER, skip);
    write_reg(REG_REFERENCE_LENGTH, len);
  endtask

  task automatic run_contig();
    int          ncols;
    int          r;
    logic [31:0] pos;
    col_flavor_t flavor;
    ncols = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 14);
    r = $urandom_range(0, 7);
    if (r == 0) pos = 32'hFFFF_FFFF - $urandom_range(0, 20);
    else if (r == 1) pos = $urandom();
    else pos = $urandom_range(0, 300);
    flavor = COL_CLEAN;
    for (int k = 0; k < ncols; k++) begin
      flavor = pick_flavor(flavor);
      send_request(make_column(pos, flavor));
      random_items++;
      r = $urandom_range(0, 19);
      if (r < 15) pos = pos + 1;
      else if (r < 18) pos = pos + $urandom_range(2, 30);
      else if (r == 19) pos = pos - $urandom_range(1, 5);
    end
    send_request(end_request());
    random_items++;
  endtask

  initial begin : receiver
    int stall_left;
    int free_left;
    int hold_left;
    stall_left = 0;
    free_left  = 0;
    hold_left  = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (free_left > 0) begin
          free_left--;
        end else begin
          free_left  = $urandom_range(0, 12);
          stall_left = pick_gap(out_calm);
        end
      end
    end
  end

  initial begin : stimulus
    int          phase;
    int          phase_goal;
    int          waited;
    logic [31:0] cov;
    logic [31:0] len;
    in_calm      = 1'b0;
    out_calm     = 1'b0;
    hold_req     = 1'b0;
    random_items = 0;
    rst_n    <= 1'b0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    in_valid <= 1'b0;
    req      <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    repeat (SETTLE_CYCLES) @(posedge clk);

    // An end request before any column reports an empty contig.
    send_request(end_request());
    send_request(end_request());
    configure(32'd4, 32'h0000_8000, 32'd0, 32'd1000);
    send_request(column_of(32'd0, 0, 10, 0, 0, 0, 0, 0, WIN_PLAIN));
    send_request(end_request());
    send_request(column_of(32'hFFFF_FFFF, 0, 2, 0, 0, 0, 0, 0, WIN_PLAIN));
    send_request(end_request());
    send_request(column_of(32'd5, 0, 2, 0, 0, 0, 8, 0, WIN_RIGHT_HP));
    send_request(column_of(32'd6, 0, 2, 0, 0, 0, 8, 0, WIN_PLAIN));
    send_request(column_of(32'd7, 0, 2, 0, 0, 0, 8, 0, WIN_PLAIN));
    send_request(column_of(32'd8, 0, 2, 8, 0, 0, 0, 0, WIN_PLAIN));
    send_request(column_of(32'd9, 0, 10, 0, 0, 0, 0, 6, WIN_PLAIN));
    send_request(column_of(32'd10, 0, 10, 0, 0, 0, 0, 6, WIN_RIGHT_HP));
    send_request(column_of(32'd11, 0, 0, 0, 0, 0, 0, 0, WIN_PLAIN));
    send_request(column_of(32'd11, 0, 2, 0, 0, 8, 0, 0, WIN_PLAIN));
    send_request(column_of(32'd2, 0, 2, 0, 0, 0, 0, 0, WIN_PLAIN));
    send_request(column_of(32'd20, 10, 0, 0, 0, 0, 0, 0, WIN_LOWER_REF));
    send_request(column_of(32'd21, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                           16'hFFFF, 16'hFFFF, 56'hFF_FFFF_FFFF_FFFF));
    send_request(column_of(32'd1, 0, 2, 0, 0, 0, 8, 0, WIN_LEFT_HP));
    send_request(column_of(32'd998, 0, 2, 0, 0, 0, 8, 0, WIN_RIGHT_HP));
    send_request(column_of(32'd999, 0, 2, 0, 0, 0, 8, 0, WIN_LEFT_HP));
    send_request(column_of(32'd3, 0, 10, 0, 0, 0, 0, 6, WIN_LEFT_HP));
    send_request(end_request());

    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      case (phase)
        0: configure(32'd0, 32'd0, 32'd1, 32'hFFFF_FFFF);
        1: configure(32'd65535, 32'd65536, 32'd0, 32'd0);
        2: configure(32'd3, 32'h0000_8000, 32'd1, 32'd200);
        3: configure(32'd1, 32'h0000_4000, 32'd0, 32'hFFFF_FFFF);
        default: begin
          cov = ($urandom_range(0, 3) == 0) ? 32'd65535 : $urandom_range(0, 20);
          len = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF : $urandom_range(0, 400);
          configure(cov, $urandom_range(0, 65536), $urandom_range(0, 1), len);
        end
      endcase
      // The long receiver hold lets the queue fill while requests keep coming.
      in_calm  = (phase == 2 || phase == 3);
      out_calm = (phase == 3);
      hold_req = (phase == 2);
      phase_goal = random_items + 25;
      while (random_items < phase_goal) run_contig();
      phase++;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (board.outstanding() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    board.count_leftover();
    if (board.failures == 0) begin
      $display("pileup_diff_run_classifier_top regression: pass");
    end else begin
      $display("pileup_diff_run_classifier_top regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("pileup_diff_run_classifier_top regression: fail");
    $finish;
  end

endmodule
